### hw/rtl/kcw_pkg.sv
// kcw_pkg: shared defaults and sideband types for the knee/cut waveshaper
`default_nettype none

package kcw_pkg;

  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_FRAC_BITS    = 22;
  // numerator and divisor widths that follow from the defaults above
  localparam int DEF_NUM_WIDTH    = 49;
  localparam int DEF_DIV_WIDTH    = 23;

  typedef struct packed {
    logic pass;
    logic neg;
    logic ovf;
  } kcw_flags_t;

endpackage

`default_nettype wire

### hw/rtl/kcw_div_pipe.sv
// kcw_div_pipe: pipelined restoring divider, one quotient bit per stage, with overflow check
`default_nettype none

module kcw_div_pipe
  import kcw_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int NUM_WIDTH    = DEF_NUM_WIDTH,
  parameter int DIV_WIDTH    = DEF_DIV_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [NUM_WIDTH-1:0]    in_num,
  input  wire logic [DIV_WIDTH-1:0]    in_div,
  input  wire kcw_flags_t              in_flags,
  input  wire logic [SAMPLE_WIDTH-1:0] in_x,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0]      out_quot,
  output kcw_flags_t                   out_flags,
  output logic [SAMPLE_WIDTH-1:0]      out_x
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int RW = (NUM_WIDTH > DIV_WIDTH + W) ? NUM_WIDTH : DIV_WIDTH + W;

  logic                 v    [0:W];
  logic [W+1:0]         en;
  logic [RW-1:0]        rem  [0:W-1];
  logic [DIV_WIDTH-1:0] dv   [0:W-1];
  logic [W-1:0]         quot [0:W];
  kcw_flags_t           fl   [0:W];
  logic [W-1:0]         xs   [0:W];

  logic          ovf0;
  logic [RW-1:0] num0;

  assign en[W+1] = out_ready;
  assign in_ready = en[0];

  genvar s;
  generate
    for (s = 0; s <= W; s++) begin : g_en
      assign en[s] = !v[s] || en[s+1];
    end
  endgenerate

  // overflow when the quotient would not fit in W bits
  assign num0 = RW'(in_num);
  assign ovf0 = num0 >= (RW'(in_div) << W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
    if (en[0]) begin
      rem[0]  <= num0;
      dv[0]   <= in_div;
      quot[0] <= '0;
      fl[0]   <= '{pass: in_flags.pass, neg: in_flags.neg, ovf: in_flags.ovf || ovf0};
      xs[0]   <= in_x;
    end
  end

  generate
    for (s = 1; s <= W; s++) begin : g_step
      localparam int B = W - s;
      logic [RW-1:0] trial;
      logic          take;
      logic [W-1:0]  qn;

      assign trial = RW'(dv[s-1]) << B;
      assign take  = rem[s-1] >= trial;
      assign qn    = quot[s-1] | (W'(take) << B);

      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (en[s]) begin
          v[s] <= v[s-1];
        end
        if (en[s]) begin
          quot[s] <= qn;
          fl[s]   <= fl[s-1];
          xs[s]   <= xs[s-1];
        end
      end

      if (s < W) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[s]) begin
            rem[s] <= take ? (rem[s-1] - trial) : rem[s-1];
            dv[s]  <= dv[s-1];
          end
        end
      end
    end
  endgenerate

  assign out_valid = v[W];
  assign out_quot  = quot[W];
  assign out_flags = fl[W];
  assign out_x     = xs[W];

endmodule

`default_nettype wire

### hw/rtl/knee_cut_waveshaper.sv
// knee_cut_waveshaper: soft-knee waveshaper with saturation, fully pipelined
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata: sample, knee_signal, cut_signal
//                                    tuser: use_knee_signal, use_cut_signal
//  m_*       out  tvalid/tready      tdata: shaped_sample; tuser: clipped
//  wr_*      in   wr_en              wr_index, wr_data (knee_level, cut_level)
//
//  one beat per cycle sustained while m_tready stays high; the divider resolves
//  one quotient bit per stage
//  rst clears all stage valid bits and loads the default knee and cut levels
//  each stage holds while its successor is full, so bubbles close up and a stall
//  loses nothing; s_tready drops only when every stage and the output are full
`default_nettype none

module knee_cut_waveshaper
  import kcw_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // sample, knee_signal, cut_signal
  input  wire logic [((3*SAMPLE_WIDTH-1+7)/8)*8-1:0] s_tdata,
  // use_knee_signal, use_cut_signal
  input  wire logic [1:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // shaped_sample
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_tdata,
  // clipped
  output logic [0:0]                               m_tuser,
  input  wire logic                                wr_en,
  input  wire logic [0:0]                          wr_index,
  input  wire logic [SAMPLE_WIDTH-2:0]             wr_data
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OUT_DW = ((W + 7) / 8) * 8;
  localparam int KW     = W - 1 + F;
  localparam int PW     = 2 * W;
  localparam int NW     = ((PW > KW) ? PW : KW) + 1;
  localparam int DW     = (W - 1 > F + 1) ? W - 1 : F + 1;

  localparam logic [63:0] ONE_FULL   = 64'd1 << F;
  localparam logic [63:0] KNEE_FULL  = ONE_FULL / 64'd10;
  localparam logic [63:0] CUT_FULL   = (ONE_FULL * 64'd3) / 64'd10;
  localparam logic [63:0] FLOOR_FULL = ONE_FULL / 64'd1000000;

  localparam logic [W-2:0]  KNEE_RST  = KNEE_FULL[W-2:0];
  localparam logic [W-2:0]  CUT_RST   = CUT_FULL[W-2:0];
  localparam logic [W-2:0]  CUT_FLOOR = FLOOR_FULL[W-2:0];
  localparam logic [DW-1:0] DIV_ONE   = DW'(1) << F;
  localparam logic [W-1:0]  MAX_POS   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_NEG   = {1'b1, {(W-1){1'b0}}};

  localparam logic [0:0] REG_KNEE = 1'b0;
  localparam logic [0:0] REG_CUT  = 1'b1;

  logic [W-2:0] knee_level;
  logic [W-2:0] cut_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      knee_level <= KNEE_RST;
      cut_level  <= CUT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_KNEE: knee_level <= wr_data;
        REG_CUT:  cut_level  <= wr_data;
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  logic a_en, b_en, c_en, d_en, e_en;
  logic a_valid, b_valid, c_valid, d_valid;
  logic div_in_ready, div_out_valid;

  assign e_en     = !m_tvalid || m_tready;
  assign d_en     = !d_valid || div_in_ready;
  assign c_en     = !c_valid || d_en;
  assign b_en     = !b_valid || c_en;
  assign a_en     = !a_valid || b_en;
  assign s_tready = a_en;

  // stage a: select knee and cut, take |x|
  logic [W-1:0]   in_x;
  logic [W-2:0]   in_k;
  logic [W-1:0]   in_c;
  logic [W-1:0]   a_x, a_ax, a_c;
  logic [W-2:0]   a_k;

  assign in_x = s_tdata[W-1:0];
  assign in_k = s_tuser[0] ? s_tdata[2*W-2:W] : knee_level;
  assign in_c = s_tuser[1] ? s_tdata[3*W-2:2*W-1] : {1'b0, cut_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= s_tvalid;
    end
    if (a_en) begin
      a_x  <= in_x;
      a_ax <= in_x[W-1] ? (W'(0) - in_x) : in_x;
      a_k  <= in_k;
      a_c  <= in_c;
    end
  end

  // stage b: knee compare, slope, divisor select
  logic [W:0]    a_diff, a_ndiff;
  logic          a_cgt;
  logic [W-1:0]  b_x, b_axk, b_slope;
  logic          b_pass, b_xpos, b_pneg;
  logic [DW-1:0] b_d;
  logic [KW-1:0] b_kk;

  assign a_diff  = {a_c[W-1], a_c} - (W+1)'(a_k);
  assign a_ndiff = (W+1)'(0) - a_diff;
  assign a_cgt   = !a_c[W-1] && (a_c[W-2:0] > CUT_FLOOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
    if (b_en) begin
      b_x     <= a_x;
      b_pass  <= a_ax < W'(a_k);
      b_xpos  <= !a_x[W-1] && (a_x != '0);
      b_axk   <= a_ax - W'(a_k);
      b_pneg  <= a_diff[W];
      b_slope <= a_diff[W] ? a_ndiff[W-1:0] : a_diff[W-1:0];
      b_d     <= a_cgt ? DW'(a_c[W-2:0]) : DIV_ONE;
      b_kk    <= KW'(a_k) << F;
    end
  end

  // stage c: product
  logic [W-1:0]  c_x;
  logic          c_pass, c_xpos, c_pneg;
  logic [PW-1:0] c_prod;
  logic [DW-1:0] c_d;
  logic [KW-1:0] c_kk;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= b_valid;
    end
    if (c_en) begin
      c_x    <= b_x;
      c_pass <= b_pass;
      c_xpos <= b_xpos;
      c_pneg <= b_pneg;
      c_prod <= PW'(b_axk) * PW'(b_slope);
      c_d    <= b_d;
      c_kk   <= b_kk;
    end
  end

  // stage d: signed numerator as magnitude and sign
  logic [NW-1:0] c_kkx, c_px, c_num;
  logic          c_nneg;
  logic [W-1:0]  d_x;
  logic [NW-1:0] d_num;
  logic [DW-1:0] d_d;
  kcw_flags_t    d_flags;

  assign c_kkx = NW'(c_kk);
  assign c_px  = NW'(c_prod);

  always_comb begin
    c_nneg = 1'b0;
    if (!c_pneg) begin
      c_num = c_kkx + c_px;
    end else if (c_kkx >= c_px) begin
      c_num = c_kkx - c_px;
    end else begin
      c_num  = c_px - c_kkx;
      c_nneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_en) begin
      d_valid <= c_valid;
    end
    if (d_en) begin
      d_x     <= c_x;
      d_num   <= c_num;
      d_d     <= c_d;
      d_flags <= '{pass: c_pass, neg: (c_xpos ? c_nneg : !c_nneg), ovf: 1'b0};
    end
  end

  logic [W-1:0] q_quot, q_x;
  kcw_flags_t   q_flags;

  kcw_div_pipe #(
    .SAMPLE_WIDTH (W),
    .NUM_WIDTH    (NW),
    .DIV_WIDTH    (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (div_in_ready),
    .in_num    (d_num),
    .in_div    (d_d),
    .in_flags  (d_flags),
    .in_x      (d_x),
    .out_valid (div_out_valid),
    .out_ready (e_en),
    .out_quot  (q_quot),
    .out_flags (q_flags),
    .out_x     (q_x)
  );

  // stage e: sign, saturation, output register
  logic [W-1:0] y_next;
  logic         clip_next;
  logic [W-1:0] out_y;
  logic         out_clip;

  always_comb begin
    clip_next = 1'b0;
    if (q_flags.pass) begin
      y_next = q_x;
    end else if (q_flags.ovf) begin
      clip_next = 1'b1;
      y_next    = q_flags.neg ? MIN_NEG : MAX_POS;
    end else if (!q_flags.neg) begin
      if (q_quot > MAX_POS) begin
        clip_next = 1'b1;
        y_next    = MAX_POS;
      end else begin
        y_next = q_quot;
      end
    end else begin
      if (q_quot > MIN_NEG) begin
        clip_next = 1'b1;
        y_next    = MIN_NEG;
      end else begin
        y_next = W'(0) - q_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (e_en) begin
      m_tvalid <= div_out_valid;
    end
    if (e_en) begin
      out_y    <= y_next;
      out_clip <= clip_next;
    end
  end

  assign m_tdata    = OUT_DW'(out_y);
  assign m_tuser[0] = out_clip;

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (out_y == MAX_POS || out_y == MIN_NEG))
    else $error("clipped beat without a saturated value");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while output register empty");

  a_num_hold: assert property (@(posedge clk) disable iff (rst)
    d_valid && !div_in_ready |=> d_valid && $stable(d_num))
    else $error("numerator stage changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

### tb/knee_cut_waveshaper_tb.sv
// knee_cut_waveshaper_tb: stream-level check of the waveshaper against its own predictor
`default_nettype none

module knee_cut_waveshaper_tb
  import kcw_pkg::*;
();

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int SDATA_W = ((3*SW-1+7)/8)*8;
  localparam int MDATA_W = ((SW+7)/8)*8;
  localparam longint CUT_FLOOR = (64'sd1 <<< FB) / 1000000;
  localparam longint MAX_POS = (64'sd1 <<< (SW-1)) - 1;
  localparam longint MAX_NEG = 64'sd1 <<< (SW-1);
  localparam logic [SW-2:0] KNEE_RESET = 23'd419430;
  localparam logic [SW-2:0] CUT_RESET = 23'd1258291;
  localparam logic [0:0] REG_KNEE = 1'b0;
  localparam logic [0:0] REG_CUT = 1'b1;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic [SW-2:0] knee_sig;
    logic signed [SW-1:0] cut_sig;
    logic use_knee;
    logic use_cut;
  } sample_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic clipped;
  } shaped_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic wr_en = 1'b0;
  logic [0:0] wr_index = '0;
  logic [SW-2:0] wr_data = '0;

  logic [SW-2:0] knee_cfg = KNEE_RESET;
  logic [SW-2:0] cut_cfg = CUT_RESET;

  sample_beat_t pending_samples[$];
  shaped_beat_t expected_shaped[$];
  sample_beat_t on_bus;
  int burst_left = 0;
  int gap_left = 0;
  int accepted_in = 0;
  int hold_cycles = 0;
  int ready_tick = 0;
  int stall_mode = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  knee_cut_waveshaper dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #6 clk = ~clk;

  function automatic shaped_beat_t shape_sample(sample_beat_t b);
    longint x, k, c, ax, num, d, mag, y;
    bit nneg, neg;
    shaped_beat_t r;
    x = longint'($signed(b.sample));
    k = b.use_knee ? longint'(b.knee_sig) : longint'(knee_cfg);
    c = b.use_cut ? longint'($signed(b.cut_sig)) : longint'(cut_cfg);
    ax = (x < 0) ? -x : x;
    r.clipped = 1'b0;
    if (ax < k) begin
      r.value = b.sample;
    end else begin
      num = (k <<< FB) + (ax - k) * (c - k);
      d = (c > CUT_FLOOR) ? c : (64'sd1 <<< FB);
      nneg = num < 0;
      mag = nneg ? (-num) / d : num / d;
      neg = (x > 0) ? nneg : !nneg;
      if (!neg) begin
        if (mag > MAX_POS) begin
          mag = MAX_POS;
          r.clipped = 1'b1;
        end
        y = mag;
      end else begin
        if (mag > MAX_NEG) begin
          mag = MAX_NEG;
          r.clipped = 1'b1;
        end
        y = -mag;
      end
      r.value = y[SW-1:0];
    end
    return r;
  endfunction

  function automatic sample_beat_t make_beat(longint smp, longint knee, longint cut,
                                            bit uk, bit uc);
    sample_beat_t b;
    b.sample = smp[SW-1:0];
    b.knee_sig = knee[SW-2:0];
    b.cut_sig = cut[SW-1:0];
    b.use_knee = uk;
    b.use_cut = uc;
    return b;
  endfunction

  function automatic sample_beat_t random_beat();
    sample_beat_t b;
    int unsigned pick;
    longint k, m;
    b.use_knee = 1'($urandom_range(0, 1));
    b.use_cut = 1'($urandom_range(0, 1));
    b.knee_sig = ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 16)) : 23'($urandom);
    pick = $urandom_range(0, 3);
    if (pick == 0) b.cut_sig = 24'($urandom_range(0, 16)) - 24'sd8;
    else if (pick == 1) b.cut_sig = 24'($urandom_range(0, 4194304));
    else b.cut_sig = 24'($urandom);
    k = b.use_knee ? longint'(b.knee_sig) : longint'(knee_cfg);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      b.sample = 24'($urandom);
    end else if (pick < 8) begin
      // straddle the knee from either side
      m = k + longint'($urandom_range(0, 64)) - 32;
      if (m < 0) m = 0;
      if (m > MAX_NEG) m = MAX_NEG;
      m = $urandom_range(0, 1) ? -m : m;
      b.sample = m[SW-1:0];
    end else if (pick == 8) begin
      b.sample = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    end else begin
      b.sample = 24'($urandom_range(0, 32)) - 24'sd16;
    end
    return b;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_shaped.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(logic [SW-2:0] knee, logic [SW-2:0] cut);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_KNEE;
    wr_data <= knee;
    knee_cfg = knee;
    @(posedge clk);
    wr_index <= REG_CUT;
    wr_data <= cut;
    cut_cfg = cut;
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) pending_samples.push_back(random_beat());
    wait_drained();
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) expected_shaped.push_back(shape_sample(on_bus));
      if (!s_tvalid || s_tready) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left = $urandom_range(1, 12);
          end
        end
        if (burst_left > 0 && pending_samples.size() > 0) begin
          on_bus = pending_samples.pop_front();
          s_tdata <= {1'b0, on_bus.cut_sig, on_bus.knee_sig, on_bus.sample};
          s_tuser <= {on_bus.use_cut, on_bus.use_knee};
          s_tvalid <= 1'b1;
          burst_left--;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall patterns plus two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accepted_in++;
        if (accepted_in == 100 || accepted_in == 600) hold_cycles = 160;
      end
      ready_tick++;
      if (ready_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= (ready_tick % 5 < 3);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    shaped_beat_t exp_beat;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_shaped.size() == 0) begin
        $display("%0t unexpected beat: shaped_sample %0d clipped %0b", $time,
                 $signed(m_tdata[SW-1:0]), m_tuser[0]);
        mismatches++;
      end else begin
        exp_beat = expected_shaped.pop_front();
        if (m_tdata[SW-1:0] !== exp_beat.value) begin
          $display("%0t shaped_sample mismatch: expected %0d actual %0d", $time,
                   exp_beat.value, $signed(m_tdata[SW-1:0]));
          mismatches++;
        end
        if (m_tuser[0] !== exp_beat.clipped) begin
          $display("%0t clipped mismatch: expected %0b actual %0b", $time,
                   exp_beat.clipped, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("knee_cut_waveshaper_tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset levels: knee 0.1, cut 0.3
    pending_samples.push_back(make_beat(0, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(MAX_POS, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(-MAX_NEG, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(1, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(-1, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(419430, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(-419430, 0, 0, 0, 0));
    pending_samples.push_back(make_beat(419429, 0, 0, 0, 0));
    // zero sample with zero knee
    pending_samples.push_back(make_beat(0, 0, 1258291, 1, 1));
    pending_samples.push_back(make_beat(0, 0, -5, 1, 0));
    // cut at and around the floor, zero and negative
    pending_samples.push_back(make_beat(3000000, 0, 0, 0, 1));
    pending_samples.push_back(make_beat(-3000000, 0, -1, 0, 1));
    pending_samples.push_back(make_beat(3000000, 0, 4, 0, 1));
    pending_samples.push_back(make_beat(3000000, 0, 5, 0, 1));
    pending_samples.push_back(make_beat(-3000000, 0, MAX_POS, 0, 1));
    pending_samples.push_back(make_beat(5000000, 0, -MAX_NEG, 0, 1));
    // knee above cut
    pending_samples.push_back(make_beat(-MAX_NEG, MAX_POS, 41943, 1, 1));
    pending_samples.push_back(make_beat(MAX_POS, MAX_POS, 0, 1, 1));
    pending_samples.push_back(make_beat(6000000, 4000000, 0, 1, 0));
    // saturation on both sides
    pending_samples.push_back(make_beat(-MAX_NEG, 0, -MAX_NEG, 1, 1));
    pending_samples.push_back(make_beat(MAX_POS, 0, -MAX_NEG, 1, 1));
    pending_samples.push_back(make_beat(MAX_POS, 0, 2, 1, 1));
    pending_samples.push_back(make_beat(-MAX_NEG, 16, -3, 1, 1));
    wait_drained();

    run_random(PHASE_ITEMS);
    write_levels(23'd4, 23'd41943);
    run_random(PHASE_ITEMS);
    write_levels(23'd8388607, 23'd4194304);
    run_random(PHASE_ITEMS);
    write_levels(23'd4, 23'd4194304);
    run_random(PHASE_ITEMS);
    write_levels(23'($urandom_range(4, 8388607)), 23'($urandom_range(41943, 4194304)));
    run_random(PHASE_ITEMS);

    if (mismatches == 0 && expected_shaped.size() == 0) begin
      $display("knee_cut_waveshaper_tb passed");
    end else begin
      $display("knee_cut_waveshaper_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
